// File: sv/ilie_pkg.sv
// Shared types and constants for the indexed list block.
// No dependencies; imported by every module of the block.
package ilie_pkg;

   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 3;
   localparam int POS_W   = 5;
   localparam int COUNT_W = 5;

   // operation codes carried by req_func
   typedef enum logic [FUNC_W-1:0] {
      FUNC_APPEND      = 3'd0,
      FUNC_REMOVE_LAST = 3'd1,
      FUNC_INSERT      = 3'd2,
      FUNC_ERASE       = 3'd3,
      FUNC_READ        = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // command broadcast to the row of cells for one beat
   typedef struct packed {
      logic ins;   // load value at index, cells above take from below
      logic del;   // cells at and above index take from above
      logic rd;    // cell at index drives the read chain
   } cell_cmd_type;

endpackage

// File: sv/ilie_cell.sv
// One storage cell of the list row: holds a single entry.
// Depends on ilie_pkg.
module ilie_cell #(
   parameter int IDX = 0,
   parameter int HW  = 5
) (
   input  logic                             clock,
   input  ilie_pkg::cell_cmd_type           cmd,
   input  logic [HW-1:0]                    index,
   input  logic [ilie_pkg::DATA_W-1:0]      value,
   input  logic [ilie_pkg::DATA_W-1:0]      left_data,
   input  logic [ilie_pkg::DATA_W-1:0]      right_data,
   input  logic [ilie_pkg::DATA_W-1:0]      rd_in,
   output logic [ilie_pkg::DATA_W-1:0]      data,
   output logic [ilie_pkg::DATA_W-1:0]      rd_out
);
   import ilie_pkg::*;

   localparam logic [HW-1:0] MY_IDX = HW'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_index;
   logic              above_index;

   assign at_index    = (MY_IDX == index);
   assign above_index = (MY_IDX > index);

   // next entry: load, shift up from the left, shift down from the right
   always_comb begin
      data_in = data_ff;
      if (cmd.ins) begin
         if (at_index) begin
            data_in = value;
         end else if (above_index) begin
            data_in = left_data;
         end
      end else if (cmd.del) begin
         if (at_index || above_index) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

   // read chain: the selected cell ORs its entry in
   assign rd_out = rd_in | ((cmd.rd && at_index) ? data_ff : '0);

endmodule

// File: sv/ilie_ctrl.sv
// Operation decode, range checks and entry count for the list.
// Depends on ilie_pkg; drives the command for the row of cells.
module ilie_ctrl #(
   parameter int DEPTH = 16,
   parameter int HW    = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [ilie_pkg::FUNC_W-1:0]      func,
   input  logic [ilie_pkg::POS_W-1:0]       position,
   output ilie_pkg::cell_cmd_type           cmd,
   output logic [HW-1:0]                    index,
   output ilie_pkg::status_type             status,
   output logic [ilie_pkg::COUNT_W-1:0]     count
);
   import ilie_pkg::*;

   localparam int CMPW = (HW > POS_W) ? HW : POS_W;

   logic [HW-1:0]   held_ff;
   logic [HW-1:0]   held_in;
   logic [CMPW-1:0] pos_w;
   logic [CMPW-1:0] held_w;
   logic [CMPW-1:0] pos_m1;
   logic            pos_ok;
   logic            full;
   logic            empty;

   assign pos_w  = CMPW'(position);
   assign held_w = CMPW'(held_ff);
   assign pos_m1 = pos_w - 1'b1;
   assign pos_ok = (pos_w != '0) && (pos_w <= held_w);
   assign full   = (held_w == CMPW'(DEPTH));
   assign empty  = (held_ff == '0);

   // decode one beat into a cell command, status and new count
   always_comb begin
      cmd     = '0;
      index   = pos_m1[HW-1:0];
      status  = ST_DONE;
      held_in = held_ff;
      unique case (func_type'(func))
         FUNC_APPEND: begin
            index = held_ff;
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = accept;
               held_in = held_ff + 1'b1;
            end
         end
         FUNC_REMOVE_LAST: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               held_in = held_ff - 1'b1;
            end
         end
         FUNC_INSERT: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.ins = accept;
               held_in = held_ff + 1'b1;
            end
         end
         FUNC_ERASE: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else begin
               cmd.del = accept;
               held_in = held_ff - 1'b1;
            end
         end
         FUNC_READ: begin
            if (!pos_ok) begin
               status = ST_RANGE;
            end else begin
               cmd.rd = accept;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   assign count = COUNT_W'(held_in);

endmodule

// File: sv/indexed_list_insert_erase.sv
// Top level of the indexed list: decode, row of cells, result register.
// Depends on ilie_pkg, ilie_ctrl and ilie_cell.
//
// Ordered list of up to DEPTH signed 32-bit entries. One operation is taken
// per clock (start high while busy is low) and its result appears on the
// rsp_ ports in the next cycle, marked by rsp_strobe for exactly one cycle;
// results cannot be held off. Operations never wait on one another, because
// each entry lives in a cell of its own and the whole row shifts in parallel
// on insert and erase. busy is high only during reset and the cycle after it.
// Rejected operations leave the list unchanged and report a status; count
// shows the entries held after the operation, as its low five bits.
module indexed_list_insert_erase #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ilie_pkg::FUNC_W-1:0]      req_func,
   input  logic [ilie_pkg::POS_W-1:0]       req_position,
   input  logic signed [ilie_pkg::DATA_W-1:0] req_value,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic signed [ilie_pkg::DATA_W-1:0] rsp_read_value,
   output logic [ilie_pkg::COUNT_W-1:0]     rsp_count
);
   import ilie_pkg::*;

   localparam int HW = $clog2(DEPTH + 1);

   logic                busy_ff;
   logic                accept;
   cell_cmd_type        cmd;
   logic [HW-1:0]       index;
   status_type          status;
   logic [COUNT_W-1:0]  count;
   logic [DATA_W-1:0]   cell_data [DEPTH];
   logic [DATA_W-1:0]   rd_chain  [DEPTH+1];

   logic                rsp_strobe_ff;
   logic [1:0]          rsp_status_ff;
   logic [DATA_W-1:0]   rsp_read_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   // held off during reset and the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   ilie_ctrl #(
      .DEPTH (DEPTH),
      .HW    (HW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .position (req_position),
      .cmd      (cmd),
      .index    (index),
      .status   (status),
      .count    (count)
   );

   // row of cells, read chain runs from cell 0 upward
   assign rd_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_mid_r
         assign right_data = cell_data[i+1];
      end

      ilie_cell #(
         .IDX (i),
         .HW  (HW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (index),
         .value      (req_value),
         .left_data  (left_data),
         .right_data (right_data),
         .rd_in      (rd_chain[i]),
         .data       (cell_data[i]),
         .rd_out     (rd_chain[i+1])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_read_value_ff <= rd_chain[DEPTH];
         rsp_count_ff      <= count;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_count      = rsp_count_ff;

endmodule

// File: sv/ilie_checker.sv
// Port-level checks for the indexed list, bound to the top level.
// Depends on ilie_pkg and indexed_list_insert_erase.
module ilie_checker #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic                             rsp_strobe,
   input  logic [1:0]                       rsp_status,
   input  logic [ilie_pkg::DATA_W-1:0]      rsp_read_value,
   input  logic [ilie_pkg::COUNT_W-1:0]     rsp_count
);
   import ilie_pkg::*;

   // every accepted beat answers in the next cycle
   a_answer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted beat without result");

   // no result without a beat accepted just before
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without accepted beat");

   // rejected beats carry zero read data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_DONE)) |-> (rsp_read_value == '0))
      else $error("rejected beat with nonzero read value");

   // empty list reports zero entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_EMPTY)) |-> (rsp_count == '0))
      else $error("empty status with nonzero count");

   // full list reports the full depth
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_FULL)) |-> (rsp_count == COUNT_W'(DEPTH)))
      else $error("full status with wrong count");

endmodule

bind indexed_list_insert_erase ilie_checker #(
   .DEPTH (DEPTH)
) u_ilie_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_read_value (rsp_read_value),
   .rsp_count      (rsp_count)
);
